// File: rtl/core/fup_pkg.sv
// Shared types, codes and helper functions of the form field parser.
package fup_pkg;

  localparam int unsigned MAX_FIELDS = 65535;
  localparam logic [15:0] FCNT_LIMIT = 16'(MAX_FIELDS - 1);
  localparam int unsigned NUM_SLOTS  = 5;
  localparam int unsigned NUM_CANDS  = 8;

  localparam logic [7:0] SEP_RESET   = 8'd38;
  localparam logic [7:0] DELIM_RESET = 8'd61;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // Configuration register indexes.
  localparam logic CFG_FIELD_SEP = 1'b0;
  localparam logic CFG_NV_DELIM  = 1'b1;

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_END   = 3'd2,
    KIND_OK    = 3'd3,
    KIND_ERR   = 3'd4
  } fup_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_DATA  = 2'd1,
    ERR_NO_DELIM = 2'd2
  } fup_err_e;

  typedef enum logic [2:0] {
    PH_NAME  = 3'b001,
    PH_VALUE = 3'b010,
    PH_ERROR = 3'b100
  } fup_phase_e;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HIGH = 3'b100
  } fup_esc_e;

  typedef struct packed {
    fup_phase_e  phase;
    fup_esc_e    esc;
    logic [7:0]  held;
    logic        sep_seen;
    logic [15:0] fcnt;
  } fup_state_t;

  typedef struct packed {
    fup_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] fnum;
    fup_err_e    err;
  } fup_result_t;

  typedef struct packed {
    logic [2:0]                   cnt;
    fup_result_t [NUM_SLOTS-1:0]  slot;
  } fup_bundle_t;

  localparam fup_state_t STATE_RESET = '{
    phase:    PH_NAME,
    esc:      ESC_IDLE,
    held:     8'h00,
    sep_seen: 1'b0,
    fcnt:     16'h0000
  };

  // Returns {valid, nibble} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_UA && c <= CHAR_UA + 8'd5) begin
      r = {1'b1, 4'(c - CHAR_UA + 8'd10)};
    end else if (c >= CHAR_LA && c <= CHAR_LA + 8'd5) begin
      r = {1'b1, 4'(c - CHAR_LA + 8'd10)};
    end else if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
      r = {1'b1, 4'(c - CHAR_ZERO)};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

// File: rtl/core/fup_decode.sv
// Combinational decode of one byte: next parser state and its result bundle.
module fup_decode (
  input  fup_pkg::fup_state_t  state_i,
  input  logic [7:0]           field_sep_i,
  input  logic [7:0]           nv_delim_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 last_i,
  output fup_pkg::fup_state_t  state_o,
  output fup_pkg::fup_bundle_t bundle_o
);

  fup_pkg::fup_state_t                           st;
  fup_pkg::fup_result_t [fup_pkg::NUM_CANDS-1:0] cand;
  logic [fup_pkg::NUM_CANDS-1:0]                 cand_en;
  fup_pkg::fup_kind_e                            data_kind;
  logic [4:0]                                    byte_hex;
  logic [4:0]                                    held_hex;
  logic                                          is_sep;
  logic                                          is_delim;
  logic                                          flush_pct;
  logic                                          flush_held;
  logic [7:0]                                    esc_val;
  logic [2:0]                                    n;

  assign byte_hex   = fup_pkg::hex_decode(in_byte_i);
  assign held_hex   = fup_pkg::hex_decode(state_i.held);
  assign is_sep     = (in_byte_i == field_sep_i);
  assign is_delim   = (in_byte_i == nv_delim_i);
  assign flush_pct  = (state_i.esc == fup_pkg::ESC_PCT) || (state_i.esc == fup_pkg::ESC_HIGH);
  assign flush_held = (state_i.esc == fup_pkg::ESC_HIGH) && (state_i.held != fup_pkg::CHAR_LF);
  assign esc_val    = {held_hex[3:0], byte_hex[3:0]};
  assign data_kind  = (state_i.phase == fup_pkg::PH_VALUE) ? fup_pkg::KIND_VALUE
                                                           : fup_pkg::KIND_NAME;

  // Candidate slots in emission order: three data bytes from the byte and its pending escape,
  // field end on a separator, two flush bytes at the end, end/error, done ok.
  always_comb begin
    st      = state_i;
    cand_en = '0;
    for (int i = 0; i < fup_pkg::NUM_CANDS; i++) begin
      cand[i].kind = data_kind;
      cand[i].data = 8'h00;
      cand[i].fnum = state_i.fcnt;
      cand[i].err  = fup_pkg::ERR_NONE;
    end

    if (state_i.phase != fup_pkg::PH_NAME && state_i.phase != fup_pkg::PH_VALUE) begin
      // error phase: drop the byte
    end else if (is_sep) begin
      if (state_i.phase == fup_pkg::PH_NAME) begin
        st.phase = fup_pkg::PH_ERROR;
        st.esc   = fup_pkg::ESC_IDLE;
        st.held  = 8'h00;
      end else begin
        cand_en[0]   = flush_pct;
        cand[0].data = fup_pkg::CHAR_PCT;
        cand_en[1]   = flush_held;
        cand[1].data = fup_pkg::plain_byte(state_i.held);
        cand_en[3]   = 1'b1;
        cand[3].kind = fup_pkg::KIND_END;
        st.esc       = fup_pkg::ESC_IDLE;
        st.held      = 8'h00;
        if (state_i.fcnt < fup_pkg::FCNT_LIMIT) begin
          st.fcnt = state_i.fcnt + 16'd1;
        end
        st.phase    = fup_pkg::PH_NAME;
        st.sep_seen = 1'b1;
      end
    end else if (state_i.phase == fup_pkg::PH_NAME && is_delim) begin
      cand_en[0]   = flush_pct;
      cand[0].data = fup_pkg::CHAR_PCT;
      cand_en[1]   = flush_held;
      cand[1].data = fup_pkg::plain_byte(state_i.held);
      st.esc       = fup_pkg::ESC_IDLE;
      st.held      = 8'h00;
      st.phase     = fup_pkg::PH_VALUE;
    end else begin
      case (state_i.esc)
        fup_pkg::ESC_PCT: begin
          if (byte_hex[4]) begin
            st.held = in_byte_i;
            st.esc  = fup_pkg::ESC_HIGH;
          end else begin
            // bad escape: pass '%' and rescan the byte
            cand_en[0]   = 1'b1;
            cand[0].data = fup_pkg::CHAR_PCT;
            st.esc       = fup_pkg::ESC_IDLE;
            if (in_byte_i == fup_pkg::CHAR_PCT) begin
              st.esc = fup_pkg::ESC_PCT;
            end else begin
              cand_en[1]   = (in_byte_i != fup_pkg::CHAR_LF);
              cand[1].data = fup_pkg::plain_byte(in_byte_i);
            end
          end
        end
        fup_pkg::ESC_HIGH: begin
          st.esc  = fup_pkg::ESC_IDLE;
          st.held = 8'h00;
          if (byte_hex[4] && held_hex[4]) begin
            cand_en[0]   = (esc_val != fup_pkg::CHAR_LF);
            cand[0].data = esc_val;
          end else begin
            cand_en[0]   = 1'b1;
            cand[0].data = fup_pkg::CHAR_PCT;
            cand_en[1]   = (state_i.held != fup_pkg::CHAR_LF);
            cand[1].data = fup_pkg::plain_byte(state_i.held);
            if (in_byte_i == fup_pkg::CHAR_PCT) begin
              st.esc = fup_pkg::ESC_PCT;
            end else begin
              cand_en[2]   = (in_byte_i != fup_pkg::CHAR_LF);
              cand[2].data = fup_pkg::plain_byte(in_byte_i);
            end
          end
        end
        default: begin
          st.esc = fup_pkg::ESC_IDLE;
          if (in_byte_i == fup_pkg::CHAR_PCT) begin
            st.esc = fup_pkg::ESC_PCT;
          end else begin
            cand_en[0]   = (in_byte_i != fup_pkg::CHAR_LF);
            cand[0].data = fup_pkg::plain_byte(in_byte_i);
          end
        end
      endcase
    end

    if (last_i) begin
      case (st.phase)
        fup_pkg::PH_VALUE: begin
          cand_en[4]   = (st.esc == fup_pkg::ESC_PCT) || (st.esc == fup_pkg::ESC_HIGH);
          cand[4].kind = fup_pkg::KIND_VALUE;
          cand[4].data = fup_pkg::CHAR_PCT;
          cand[4].fnum = st.fcnt;
          cand_en[5]   = (st.esc == fup_pkg::ESC_HIGH) && (st.held != fup_pkg::CHAR_LF);
          cand[5].kind = fup_pkg::KIND_VALUE;
          cand[5].data = fup_pkg::plain_byte(st.held);
          cand[5].fnum = st.fcnt;
          cand_en[6]   = 1'b1;
          cand[6].kind = fup_pkg::KIND_END;
          cand[6].fnum = st.fcnt;
          cand_en[7]   = 1'b1;
          cand[7].kind = fup_pkg::KIND_OK;
          cand[7].fnum = st.fcnt + 16'd1;
        end
        fup_pkg::PH_NAME: begin
          cand_en[6]   = 1'b1;
          cand[6].kind = fup_pkg::KIND_ERR;
          cand[6].fnum = 16'h0000;
          cand[6].err  = st.sep_seen ? fup_pkg::ERR_NO_DELIM : fup_pkg::ERR_NO_DATA;
        end
        default: begin
          cand_en[6]   = 1'b1;
          cand[6].kind = fup_pkg::KIND_ERR;
          cand[6].fnum = 16'h0000;
          cand[6].err  = fup_pkg::ERR_NO_DELIM;
        end
      endcase
      st = fup_pkg::STATE_RESET;
    end
  end

  // Pack enabled candidates into consecutive slots.
  always_comb begin
    bundle_o = '0;
    n        = 3'd0;
    for (int i = 0; i < fup_pkg::NUM_CANDS; i++) begin
      if (cand_en[i] && n != 3'(fup_pkg::NUM_SLOTS)) begin
        bundle_o.slot[n] = cand[i];
        n                = n + 3'd1;
      end
    end
    bundle_o.cnt = n;
  end

  assign state_o = st;

endmodule

// File: rtl/core/fup_result_buf.sv
// Result register: holds a byte's results, drains one per cycle while ready.
module fup_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fup_pkg::fup_bundle_t bundle_i,
  input  logic                 out_ready_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  output fup_pkg::fup_result_t result_o,
  output logic                 run_end_o
);

  fup_pkg::fup_result_t [fup_pkg::NUM_SLOTS-1:0] slot_q;
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] idx_q, idx_d;
  logic       take;
  logic       last_slot;

  assign out_valid_o = (cnt_q != 3'd0);
  assign last_slot   = (idx_q == cnt_q - 3'd1);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == 3'd0) || (take && last_slot);
  assign result_o    = slot_q[idx_q];
  assign run_end_o   = last_slot;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.cnt;
      idx_d = 3'd0;
    end else if (take) begin
      if (last_slot) begin
        cnt_d = 3'd0;
        idx_d = 3'd0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
  end

endmodule

// File: rtl/core/form_urlencoded_field_parser_unit.sv
// Top level of the streaming form field parser (input register, decode, result register).
// A byte in the input register is decoded and loaded into the result register when that
// is free. Throughput: one byte per cycle while each byte yields at most one result and
// the output is ready; a byte with k results (up to five) holds the register until all drain.
// Reset: rst_ni clears the parser state, the pipeline valids and restores the
// separator and delimiter registers to '&' and '='.
module form_urlencoded_field_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] field_number_o,
  output logic [1:0]  error_code_o,
  output logic        run_end_o
);

  // Configuration registers.
  logic [7:0] field_sep_q;
  logic [7:0] nv_delim_q;

  // Input register: one byte transaction waiting for decode.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state, advanced once per decoded byte.
  fup_pkg::fup_state_t state_q, state_d;

  fup_pkg::fup_bundle_t bundle;
  fup_pkg::fup_result_t result;
  logic                 buf_free;
  logic                 advance;
  logic                 in_take;

  // Decode the held byte once the result register can take its bundle.
  assign advance    = in_vld_q && buf_free;
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_sep_q <= fup_pkg::SEP_RESET;
      nv_delim_q  <= fup_pkg::DELIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fup_pkg::CFG_FIELD_SEP: field_sep_q <= cfg_wdata_i;
        fup_pkg::CFG_NV_DELIM:  nv_delim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Hold the payload until the byte is decoded.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fup_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Separator wins over delimiter; escapes flush at the delimiter, at a value's separator
  // and at a value's last byte, and the last byte returns the state to reset values.
  fup_decode u_decode (
    .state_i     (state_q),
    .field_sep_i (field_sep_q),
    .nv_delim_i  (nv_delim_q),
    .in_byte_i   (in_byte_q),
    .last_i      (in_last_q),
    .state_o     (state_d),
    .bundle_o    (bundle)
  );

  // A byte with no results loads an empty bundle and leaves no trace.
  fup_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .bundle_i    (bundle),
    .out_ready_i (out_ready_i),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .result_o    (result),
    .run_end_o   (run_end_o)
  );

  assign result_kind_o  = result.kind;
  assign out_byte_o     = result.data;
  assign field_number_o = result.fnum;
  assign error_code_o   = result.err;

endmodule

// File: rtl/core/fup_checker.sv
// Port-level assertion checker for the form field parser, with its bind.
module fup_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  result_kind_o,
  input logic [7:0]  out_byte_o,
  input logic [15:0] field_number_o,
  input logic [1:0]  error_code_o,
  input logic        run_end_o
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(out_byte_o) && $stable(field_number_o) && $stable(error_code_o) &&
      $stable(run_end_o))
    else $error("stalled result changed");

  // A done status always closes the run of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == fup_pkg::KIND_OK || result_kind_o == fup_pkg::KIND_ERR)
      |-> run_end_o)
    else $error("done status not marked as run end");

  // Done error carries a nonzero code and zero byte and count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == fup_pkg::KIND_ERR
      |-> out_byte_o == 8'h00 && field_number_o == 16'h0000 &&
          error_code_o != fup_pkg::ERR_NONE)
    else $error("malformed done error result");

  // Data and field end results carry no error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == fup_pkg::KIND_NAME ||
                    result_kind_o == fup_pkg::KIND_VALUE ||
                    result_kind_o == fup_pkg::KIND_END)
      |-> error_code_o == fup_pkg::ERR_NONE)
    else $error("error code on a non-error result");

endmodule

bind form_urlencoded_field_parser_unit fup_checker u_fup_checker (.*);
